@@ src/dspm_pkg.sv @@
// shared types and constants for the display shape pixel mask
package dspm_pkg;

	localparam int unsigned CBITS = 12;
	localparam int unsigned RBITS = 11;
	localparam int unsigned CFG_W = 61;
	localparam int unsigned IDX_W = 3;

	// register indexes
	localparam logic [IDX_W-1:0] REG_PANEL_SIZE = 3'd0;
	localparam logic [IDX_W-1:0] REG_OUTLINE    = 3'd1;
	localparam logic [IDX_W-1:0] REG_RADII      = 3'd2;
	localparam logic [IDX_W-1:0] REG_CUT_COUNT  = 3'd3;
	localparam logic [IDX_W-1:0] REG_CUT_FIRST  = 3'd4;
	localparam logic [IDX_W-1:0] REG_CUT_SECOND = 3'd5;

	// outline codes
	localparam logic [1:0] OUTL_RECT   = 2'd0;
	localparam logic [1:0] OUTL_CIRCLE = 2'd1;
	localparam logic [1:0] OUTL_ROUND  = 2'd2;

	// cutout kinds
	localparam logic [1:0] KIND_RECT  = 2'd0;
	localparam logic [1:0] KIND_ROUND = 2'd1;
	localparam logic [1:0] KIND_ELLIP = 2'd2;

	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
	} pix_t;

	typedef struct packed {
		logic visible;
		logic profile_ok;
	} mask_t;

endpackage

@@ src/dspm_stream_if.sv @@
// valid/ready channel carrying one payload
interface dspm_stream_if #(
	parameter int unsigned W = 1
);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/display_shape_pixel_mask.sv @@
// top level of the display shape pixel mask
//  channel | dir | payload
//  pix     | in  | pixel_x, pixel_y
//  mask    | out | visible, profile_ok
//  cfg     | in  | cfg_we, cfg_idx, cfg_data
// one pixel per cycle while the output is not stalled; five register stages, stage 1 to
// stage 5, lie between a pixel transaction and its result
// reset clears the valid bits, the profile registers and the profile flag; payload
// registers are not reset
// a stall on the output freezes every stage in place; nothing is lost or repeated
module display_shape_pixel_mask #(
	parameter int unsigned MAX_CUTOUTS = 2,
	parameter int unsigned COORD_BITS  = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [dspm_pkg::IDX_W-1:0]  cfg_idx,
	input  logic [dspm_pkg::CFG_W-1:0]  cfg_data,
	dspm_stream_if.sink                 pix,
	dspm_stream_if.source               mask
);
	import dspm_pkg::*;

	localparam logic [11:0] CMASK = 12'((13'd1 << COORD_BITS) - 13'd1);
	localparam int unsigned NST = 5;

	logic [23:0] panel_size_q;
	logic [1:0]  outline_q;
	logic [43:0] radii_q;
	logic [1:0]  cut_count_q;
	logic [60:0] cut_q [2];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_size_q <= '0;
			outline_q    <= '0;
			radii_q      <= '0;
			cut_count_q  <= '0;
			cut_q[0]     <= '0;
			cut_q[1]     <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_PANEL_SIZE: panel_size_q <= cfg_data[23:0];
				REG_OUTLINE:    outline_q    <= cfg_data[1:0];
				REG_RADII:      radii_q      <= cfg_data[43:0];
				REG_CUT_COUNT:  cut_count_q  <= cfg_data[1:0];
				REG_CUT_FIRST:  cut_q[0]     <= cfg_data;
				REG_CUT_SECOND: cut_q[1]     <= cfg_data;
				default: ;
			endcase
		end
	end

	// decoded fields
	logic [11:0] pw, ph, mind;
	logic [10:0] cr [4];
	logic [11:0] cx [2], cy [2], cw [2], chh [2];
	logic [1:0]  ck [2];
	logic [10:0] crr [2];
	logic [1:0]  ncut;
	logic        ok;

	always_comb begin
		pw   = panel_size_q[11:0] & CMASK;
		ph   = panel_size_q[23:12] & CMASK;
		mind = (pw < ph) ? pw : ph;
		ncut = (32'(cut_count_q) > MAX_CUTOUTS) ? 2'(MAX_CUTOUTS) : cut_count_q;
		for (int k = 0; k < 4; k++) cr[k] = radii_q[11*k +: 11];
		for (int k = 0; k < 2; k++) begin
			cx[k]  = cut_q[k][11:0] & CMASK;
			cy[k]  = cut_q[k][23:12] & CMASK;
			cw[k]  = cut_q[k][35:24] & CMASK;
			chh[k] = cut_q[k][47:36] & CMASK;
			ck[k]  = cut_q[k][49:48];
			crr[k] = cut_q[k][60:50];
		end
	end

	// profile check from the static registers, registered once
	logic ok_c;
	always_comb begin
		ok_c = (pw != '0) && (ph != '0) && (32'(cut_count_q) <= MAX_CUTOUTS);
		for (int k = 0; k < 4; k++) if ({1'b0, cr[k]} > mind[11:1]) ok_c = 1'b0;
		for (int k = 0; k < 2; k++) begin
			if (k < int'(ncut)) begin
				if (ck[k] > KIND_ELLIP || cw[k] == '0 || chh[k] == '0 ||
				    ({1'b0, cx[k]} + {1'b0, cw[k]} > {1'b0, pw}) ||
				    ({1'b0, cy[k]} + {1'b0, chh[k]} > {1'b0, ph})) ok_c = 1'b0;
				if (ck[k] == KIND_ROUND &&
				    {crr[k], 1'b0} > ((cw[k] < chh[k]) ? cw[k] : chh[k])) ok_c = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ok <= 1'b0;
		else ok <= ok_c;
	end

	// pipeline control
	logic [NST-1:0] vld_q;
	logic           en;
	mask_t          out_s5;
	assign en        = !vld_q[NST-1] || mask.ready;
	assign pix.ready = en;
	assign mask.valid = vld_q[NST-1];
	assign mask.data  = out_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[NST-2:0], pix.valid};
	end

	pix_t        in_pix;
	logic [11:0] x, y;
	assign in_pix = pix.data;
	assign x = in_pix.x & CMASK;
	assign y = in_pix.y & CMASK;

	// stage 1: bounds, offsets
	logic               base_s1;
	logic signed [13:0] pdx_s1, pdy_s1;
	logic [1:0]         hit_s1;
	logic signed [13:0] edx_s1 [2], edy_s1 [2];
	logic [1:0]         rk_s1, ek_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			base_s1 <= ok_c && (x < pw) && (y < ph);
			pdx_s1  <= $signed({1'b0, x, 1'b0}) + 14'sd1 - $signed({2'b0, pw});
			pdy_s1  <= $signed({1'b0, y, 1'b0}) + 14'sd1 - $signed({2'b0, ph});
			for (int k = 0; k < 2; k++) begin
				hit_s1[k] <= (k < int'(ncut)) && (x >= cx[k]) && (y >= cy[k]) &&
				             ({1'b0, x} < {1'b0, cx[k]} + {1'b0, cw[k]}) &&
				             ({1'b0, y} < {1'b0, cy[k]} + {1'b0, chh[k]});
				edx_s1[k] <= $signed({1'b0, 12'(x - cx[k]), 1'b0}) + 14'sd1
				             - $signed({2'b0, cw[k]});
				edy_s1[k] <= $signed({1'b0, 12'(y - cy[k]), 1'b0}) + 14'sd1
				             - $signed({2'b0, chh[k]});
				rk_s1[k]  <= (ck[k] == KIND_ROUND);
				ek_s1[k]  <= (ck[k] == KIND_ELLIP);
			end
		end
	end

	// corner units: panel corners and cutout corners
	logic [3:0] pc_past;
	logic [3:0] cc_past [2];
	for (genvar g = 0; g < 4; g++) begin : g_pc
		dspm_corner u_pc (.clk, .en, .x, .y, .w(pw), .h(ph), .r(cr[g]),
			.right(g == 1 || g == 2), .bottom(g >= 2), .past(pc_past[g]));
	end
	for (genvar c = 0; c < 2; c++) begin : g_cut
		for (genvar g = 0; g < 4; g++) begin : g_cc
			dspm_corner u_cc (.clk, .en, .x(12'(x - cx[c])), .y(12'(y - cy[c])),
				.w(cw[c]), .h(chh[c]), .r(crr[c]),
				.right(g == 1 || g == 2), .bottom(g >= 2), .past(cc_past[c][g]));
		end
	end

	// squares at full product width
	logic signed [27:0] pdx_sq, pdy_sq;
	logic signed [27:0] edx_sq [2], edy_sq [2];
	always_comb begin
		pdx_sq = pdx_s1 * pdx_s1;
		pdy_sq = pdy_s1 * pdy_s1;
		for (int k = 0; k < 2; k++) begin
			edx_sq[k] = edx_s1[k] * edx_s1[k];
			edy_sq[k] = edy_s1[k] * edy_s1[k];
		end
	end

	// stage 2: squares
	logic        base_s2;
	logic [27:0] psum_s2;
	logic [23:0] dd_s2;
	logic [1:0]  hit_s2, rk_s2, ek_s2;
	logic [25:0] ex2_s2 [2], ey2_s2 [2];
	logic [23:0] w2_s2 [2], h2_s2 [2];
	always_ff @(posedge clk) begin
		if (en) begin
			base_s2 <= base_s1;
			psum_s2 <= unsigned'(pdx_sq) + unsigned'(pdy_sq);
			dd_s2   <= mind * mind;
			hit_s2  <= hit_s1;
			rk_s2   <= rk_s1;
			ek_s2   <= ek_s1;
			for (int k = 0; k < 2; k++) begin
				ex2_s2[k] <= edx_sq[k][25:0];
				ey2_s2[k] <= edy_sq[k][25:0];
				w2_s2[k]  <= cw[k] * cw[k];
				h2_s2[k]  <= chh[k] * chh[k];
			end
		end
	end

	// stage 3: ellipse products
	logic        base_s3, circ_out_s3;
	logic [1:0]  hit_s3, rk_s3, ek_s3;
	logic [49:0] ta_s3 [2], tb_s3 [2];
	logic [47:0] tc_s3 [2];
	always_ff @(posedge clk) begin
		if (en) begin
			base_s3     <= base_s2;
			circ_out_s3 <= psum_s2 > {4'b0, dd_s2};
			hit_s3      <= hit_s2;
			rk_s3       <= rk_s2;
			ek_s3       <= ek_s2;
			for (int k = 0; k < 2; k++) begin
				ta_s3[k] <= ex2_s2[k] * h2_s2[k];
				tb_s3[k] <= ey2_s2[k] * w2_s2[k];
				tc_s3[k] <= w2_s2[k] * h2_s2[k];
			end
		end
	end

	// stage 4: ellipse compare, join corner results
	logic       base_s4, circ_out_s4, pc_out_s4;
	logic [1:0] cov_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			base_s4     <= base_s3;
			circ_out_s4 <= circ_out_s3;
			pc_out_s4   <= (pc_past != 4'b0);
			for (int k = 0; k < 2; k++) begin
				if (!hit_s3[k]) cov_s4[k] <= 1'b0;
				else if (rk_s3[k]) cov_s4[k] <= (cc_past[k] == 4'b0);
				else if (ek_s3[k])
					cov_s4[k] <= ({1'b0, ta_s3[k]} + {1'b0, tb_s3[k]}) <= {3'b0, tc_s3[k]};
				else cov_s4[k] <= 1'b1;
			end
		end
	end

	// stage 5: final mask
	logic vis;
	always_comb begin
		vis = base_s4;
		if (outline_q == OUTL_CIRCLE && circ_out_s4) vis = 1'b0;
		if (outline_q == OUTL_ROUND && pc_out_s4) vis = 1'b0;
		if (cov_s4 != 2'b0) vis = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s5.visible    <= vis;
			out_s5.profile_ok <= ok;
		end
	end

	// checks
	a_vis_ok: assert property (@(posedge clk) disable iff (!arst_n)
		mask.valid && out_s5.visible |-> out_s5.profile_ok)
		else $error("visible without valid profile");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mask.valid && !mask.ready |=> mask.valid && $stable(out_s5))
		else $error("output changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!mask.valid |-> pix.ready)
		else $error("input stalled with empty output");
endmodule

@@ src/dspm_corner.sv @@
// one corner arc test over three stages: offsets, squares, compare
module dspm_corner (
	input  logic        clk,
	input  logic        en,
	input  logic [11:0] x,
	input  logic [11:0] y,
	input  logic [11:0] w,
	input  logic [11:0] h,
	input  logic [10:0] r,
	input  logic        right,
	input  logic        bottom,
	output logic        past
);
	import dspm_pkg::*;

	logic               in_sq;
	logic signed [13:0] dx;
	logic signed [13:0] dy;
	logic signed [13:0] dx_s1;
	logic signed [13:0] dy_s1;
	logic               in_s1;
	logic [10:0]        r_s1;
	logic signed [27:0] dx_sq;
	logic signed [27:0] dy_sq;
	logic [27:0]        sum_s2;
	logic [21:0]        rr_s2;
	logic               in_s2;

	// corner square membership and arc center offsets
	always_comb begin
		in_sq = (r != '0);
		if (!right && ({1'b0, x} >= {2'b0, r})) in_sq = 1'b0;
		if (right && ({1'b0, x} < {1'b0, w} - {2'b0, r})) in_sq = 1'b0;
		if (!bottom && ({1'b0, y} >= {2'b0, r})) in_sq = 1'b0;
		if (bottom && ({1'b0, y} < {1'b0, h} - {2'b0, r})) in_sq = 1'b0;
		dx = right ? $signed({2'b0, x}) - ($signed({2'b0, w}) - $signed({3'b0, r}) - 14'sd1)
		           : $signed({2'b0, x}) - $signed({3'b0, r});
		dy = bottom ? $signed({2'b0, y}) - ($signed({2'b0, h}) - $signed({3'b0, r}) - 14'sd1)
		            : $signed({2'b0, y}) - $signed({3'b0, r});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= dx;
			dy_s1 <= dy;
			in_s1 <= in_sq;
			r_s1  <= r;
		end
	end

	// squares at full product width
	assign dx_sq = dx_s1 * dx_s1;
	assign dy_sq = dy_s1 * dy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= unsigned'(dx_sq) + unsigned'(dy_sq);
			rr_s2  <= r_s1 * r_s1;
			in_s2  <= in_s1;
		end
	end

	// compare
	always_ff @(posedge clk) begin
		if (en) past <= in_s2 && (sum_s2 > {6'b0, rr_s2});
	end
endmodule
